FILE: rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with contents dump.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = 5;

  // Capacity after reset and the hard limit on words in one dump.
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;
  localparam int unsigned      DUMP_LIM  = 16;

  // Command codes on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_LEFT  = 3'd0,
    CMD_PUSH_RIGHT = 3'd1,
    CMD_POP_LEFT   = 3'd2,
    CMD_POP_RIGHT  = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  // Status codes on the result channel.
  typedef enum logic [STAT_W-1:0] {
    ST_CONTENT     = 3'd0,
    ST_REFUSE_FULL = 3'd1,
    ST_REFUSE_EMPT = 3'd2,
    ST_NOW_EMPTY   = 3'd3,
    ST_QUERY_ANS   = 3'd4
  } status_t;

  // One decoded command waiting between front and back.
  typedef struct packed {
    cmd_t                     op;
    logic signed [WORD_W-1:0] value;
  } op_item_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/bdq_if.sv
// Valid/ready channel interfaces for the command beats and the result beats.
// Depends on bdq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bdq_in_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] word;
  logic                     full_flag;
  logic                     empty_flag;
  logic                     last;

  modport source (output valid, output status, output word, output full_flag,
                  output empty_flag, output last, input ready);
  modport sink   (input valid, input status, input word, input full_flag,
                  input empty_flag, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdq_front.sv
// Front end: accepts command beats, drops unused codes and queues the rest
// in a two-entry queue for the back end. Depends on bdq_pkg and bdq_if.
`timescale 1ns / 1ps
`default_nettype none

module bdq_front import bdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdq_in_if.sink     in_ch,
  output op_item_t   op_item,
  output logic       op_valid,
  input  wire logic  op_ready
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  op_item_t   q_r [2];
  logic       keep;
  logic       in_fire, push, pop;

  // Only the five defined codes enter the queue.
  always_comb begin
    unique case (in_ch.cmd) inside
      CMD_PUSH_LEFT, CMD_PUSH_RIGHT, CMD_POP_LEFT, CMD_POP_RIGHT, CMD_QUERY:
        keep = 1'b1;
      default:
        keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = in_fire && keep;
  assign op_valid    = (cnt_r != 2'd0);
  assign pop         = op_valid && op_ready;
  assign op_item     = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  // Queue entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].op    <= cmd_t'(in_ch.cmd);
      q_r[wr_ptr_r].value <= in_ch.push_value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bdq_back.sv
// Back end: holds the circular store, the deque pointers and the capacity
// register, carries out commands and streams the contents dump.
// Depends on bdq_pkg and bdq_if.
`timescale 1ns / 1ps
`default_nettype none

module bdq_back import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  op_item_t              op_item,
  input  wire logic             op_valid,
  output logic                  op_ready,
  bdq_out_if.source             out_ch
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW  = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int unsigned LIM = (DEPTH < DUMP_LIM) ? DEPTH : DUMP_LIM;
  localparam logic [CNT_W-1:0] CAP_LIM  = CNT_W'(LIM);
  localparam logic [SW-1:0]    DEPTH_S  = SW'(DEPTH);
  localparam logic [AW-1:0]    LAST_POS = AW'(DEPTH - 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     left_r, left_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_r, eff_cap;
  logic [CNT_W-1:0]  idx_r, idx_nxt, idx_sel;
  logic              rv_r, rv_nxt;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     wr_addr, rd_addr, right_pos, left_dec, left_inc;
  logic [SW-1:0]     rd_sum, wr_sum;

  logic              ov_r, ov_nxt;
  status_t           ostat_r, ostat_nxt;
  logic [WORD_W-1:0] oword_r, oword_nxt;
  logic              ofull_r, ofull_nxt, oempty_r, oempty_nxt, olast_r, olast_nxt;

  logic slot_free, op_fire, full_now, empty_now, is_push, is_pop;
  logic start_dump, dump_fire, dump_last;

  // Capacity register, to be written only while the block is idle; not enforced here.
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  // Zero counts as one; anything above the store or dump limit saturates.
  always_comb begin
    if (cap_r == '0)          eff_cap = CNT_W'(1);
    else if (cap_r > CAP_LIM) eff_cap = CAP_LIM;
    else                      eff_cap = cap_r;
  end

  assign slot_free = !ov_r || out_ch.ready;
  assign op_ready  = (state_r == BK_IDLE) && slot_free;
  assign op_fire   = op_valid && op_ready;
  assign full_now  = (count_r >= eff_cap);
  assign empty_now = (count_r == '0);
  assign is_push   = (op_item.op == CMD_PUSH_LEFT) || (op_item.op == CMD_PUSH_RIGHT);
  assign is_pop    = (op_item.op == CMD_POP_LEFT) || (op_item.op == CMD_POP_RIGHT);
  assign start_dump = (is_push && !full_now) ||
                      (is_pop && !empty_now && (count_r != CNT_W'(1)));
  assign dump_fire = (state_r == BK_DUMP) && rv_r && slot_free;
  assign dump_last = (idx_r + CNT_W'(1) == count_r);

  // Store positions: each sum stays below twice the depth, so one subtract wraps it.
  assign left_dec = (left_r == '0) ? LAST_POS : left_r - AW'(1);
  assign left_inc = (left_r == LAST_POS) ? '0 : left_r + AW'(1);
  assign wr_sum    = SW'(left_r) + SW'(count_r);
  assign right_pos = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);
  assign idx_sel   = dump_fire ? idx_r + CNT_W'(1) : idx_r;
  assign rd_sum    = SW'(left_r) + SW'(idx_sel);
  assign rd_addr   = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : AW'(rd_sum);
  assign wr_addr   = (op_item.op == CMD_PUSH_LEFT) ? left_dec : right_pos;
  assign mem_we    = op_fire && is_push && !full_now;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (op_fire && start_dump) state_nxt = BK_DUMP;
      BK_DUMP: if (dump_fire && dump_last) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Pointer updates and result beats.
  always_comb begin
    left_nxt   = left_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    rv_nxt     = 1'b0;
    ov_nxt     = slot_free ? 1'b0 : ov_r;
    ostat_nxt  = ostat_r;
    oword_nxt  = oword_r;
    ofull_nxt  = ofull_r;
    oempty_nxt = oempty_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
        if (op_fire) begin
          // Defaults for a single-beat answer taken on the current state.
          oword_nxt  = '0;
          olast_nxt  = 1'b1;
          ofull_nxt  = full_now;
          oempty_nxt = empty_now;
          if (is_push) begin
            if (full_now) begin
              ov_nxt    = 1'b1;
              ostat_nxt = ST_REFUSE_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              if (op_item.op == CMD_PUSH_LEFT) left_nxt = left_dec;
            end
          end else if (is_pop) begin
            if (empty_now) begin
              ov_nxt    = 1'b1;
              ostat_nxt = ST_REFUSE_EMPT;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              if (op_item.op == CMD_POP_LEFT) left_nxt = left_inc;
              // Popping the only word answers with a single empty beat.
              if (count_r == CNT_W'(1)) begin
                ov_nxt     = 1'b1;
                ostat_nxt  = ST_NOW_EMPTY;
                ofull_nxt  = 1'b0;
                oempty_nxt = 1'b1;
              end
            end
          end else begin
            ov_nxt    = 1'b1;
            ostat_nxt = ST_QUERY_ANS;
          end
        end
      end
      BK_DUMP: begin
        // The first cycle only fetches word zero; then one word per free slot.
        rv_nxt = 1'b1;
        if (dump_fire) begin
          ov_nxt     = 1'b1;
          ostat_nxt  = ST_CONTENT;
          oword_nxt  = rdata_r;
          ofull_nxt  = full_now;
          oempty_nxt = 1'b0;
          olast_nxt  = dump_last;
          idx_nxt    = idx_r + CNT_W'(1);
          if (dump_last) rv_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      left_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    ostat_r  <= ostat_nxt;
    oword_r  <= oword_nxt;
    ofull_r  <= ofull_nxt;
    oempty_r <= oempty_nxt;
    olast_r  <= olast_nxt;
  end

  // Circular store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= op_item.value;
    rdata_r <= mem[rd_addr];
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = ostat_r;
  assign out_ch.word       = oword_r;
  assign out_ch.full_flag  = ofull_r;
  assign out_ch.empty_flag = oempty_r;
  assign out_ch.last       = olast_r;

endmodule

`default_nettype wire

FILE: rtl/bounded_deque_with_dump.sv
// Bounded double-ended queue of 32-bit words, dumped after each non-emptying change.
//
// Channels: in_ch carries command beats (cmd, push_value), out_ch carries
// result beats (status, word, full_flag, empty_flag, last); both move a beat
// when valid and ready are high at a rising edge. cfg_we/cfg_wdata write the
// capacity register (reset value 10), to be done while the block is idle.
// A command beat is registered in the front queue; a one-beat answer (refusal,
// query, now-empty) is then registered in the output register. The back end takes
// one one-beat command per cycle while the output register is free; a push or pop
// that leaves words first updates the pointers, then fetches the first word from the
// store's registered read port, then sends one word per cycle while out_ch is ready.
// Unused codes are accepted and dropped. Reset empties the deque and the front
// queue; store contents are not cleared, and no unwritten word is ever sent.
// When the receiver stalls, the output register holds its beat, the dump
// pauses, and the front queue takes up to two more commands before in_ch.ready falls.
// Depends on bdq_pkg, bdq_if, bdq_front and bdq_back.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_dump import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bdq_in_if.sink                in_ch,
  bdq_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  op_item_t op_item;
  logic     op_valid;
  logic     op_ready;

  bdq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .op_item  (op_item),
    .op_valid (op_valid),
    .op_ready (op_ready)
  );

  bdq_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_item   (op_item),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
